[sv/iirtf_pkg.sv]
// Package for the three-form IIR biquad: types, codes and the step sequence table.
package iirtf_pkg;

  localparam int FILTER_ORDER = 2;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 32;
  localparam int HIST_W   = 48;
  localparam int ACC_W    = 56;
  localparam int PROD_W   = 57;
  localparam int LO_W     = 34;
  localparam int TERM_W   = 54;
  localparam int STEP_W   = 4;
  localparam int REG_IDX_W = 3;

  // filter_form codes
  localparam logic [1:0] FORM_DF1   = 2'd0;
  localparam logic [1:0] FORM_DF2   = 2'd1;
  localparam logic [1:0] FORM_DF2T  = 2'd2;
  localparam logic [1:0] FORM_SPARE = 2'd3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_FORM = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_B0   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_B1   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_B2   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_A1   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_A2   = 3'd5;

  // multiply phases
  localparam logic [1:0] PH_LO  = 2'd0;
  localparam logic [1:0] PH_HI  = 2'd1;
  localparam logic [1:0] PH_SUM = 2'd2;
  localparam logic [1:0] PH_ACC = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [0:0] {ST_IDLE, ST_RUN} state_e;

  typedef enum logic [1:0] {OP_LOAD, OP_MUL, OP_SAVE, OP_DONE} op_kind_e;

  typedef enum logic [2:0] {CF_B0, CF_B1, CF_B2, CF_A1, CF_A2} coef_sel_e;

  typedef enum logic [3:0] {
    OPD_ZERO, OPD_XQ, OPD_X1Q, OPD_X2Q, OPD_Y1, OPD_Y2, OPD_D0, OPD_D1, OPD_W, OPD_Y
  } opd_sel_e;

  typedef enum logic [1:0] {DST_W, DST_Y, DST_D0, DST_D1} dst_sel_e;

  typedef struct packed {
    op_kind_e  kind;
    coef_sel_e coef;
    opd_sel_e  opd;
    dst_sel_e  dst;
    logic      neg;       // subtract the product
    logic      two_only;  // second-order term, skipped for a first-order section
  } op_t;

  function automatic op_t op_mk(input op_kind_e kind, input coef_sel_e coef,
                                input opd_sel_e opd, input dst_sel_e dst,
                                input logic neg, input logic two_only);
    op_t op;
    op.kind     = kind;
    op.coef     = coef;
    op.opd      = opd;
    op.dst      = dst;
    op.neg      = neg;
    op.two_only = two_only;
    return op;
  endfunction

  function automatic op_t op_ld(input opd_sel_e opd, input logic two_only);
    return op_mk(OP_LOAD, CF_B0, opd, DST_W, 1'b0, two_only);
  endfunction

  function automatic op_t op_mul(input coef_sel_e coef, input opd_sel_e opd,
                                 input logic neg, input logic two_only);
    return op_mk(OP_MUL, coef, opd, DST_W, neg, two_only);
  endfunction

  function automatic op_t op_sv(input dst_sel_e dst, input logic two_only);
    return op_mk(OP_SAVE, CF_B0, OPD_ZERO, dst, 1'b0, two_only);
  endfunction

  function automatic op_t op_done();
    return op_mk(OP_DONE, CF_B0, OPD_ZERO, DST_W, 1'b0, 1'b0);
  endfunction

  // Step program for each form; the last step hands off the result and commits history for the direct forms.
  function automatic op_t seq_op(input logic [1:0] form, input logic [STEP_W-1:0] step);
    op_t op;
    op = op_done();
    unique case (form) inside
      FORM_DF1: begin
        unique case (step)
          4'd0:    op = op_ld(OPD_ZERO, 1'b0);
          4'd1:    op = op_mul(CF_B0, OPD_XQ,  1'b0, 1'b0);
          4'd2:    op = op_mul(CF_B1, OPD_X1Q, 1'b0, 1'b0);
          4'd3:    op = op_mul(CF_A1, OPD_Y1,  1'b1, 1'b0);
          4'd4:    op = op_mul(CF_B2, OPD_X2Q, 1'b0, 1'b1);
          4'd5:    op = op_mul(CF_A2, OPD_Y2,  1'b1, 1'b1);
          4'd6:    op = op_sv(DST_Y, 1'b0);
          default: op = op_done();
        endcase
      end
      FORM_DF2: begin
        unique case (step)
          4'd0:    op = op_ld(OPD_XQ, 1'b0);
          4'd1:    op = op_mul(CF_A1, OPD_D0, 1'b1, 1'b0);
          4'd2:    op = op_mul(CF_A2, OPD_D1, 1'b1, 1'b1);
          4'd3:    op = op_sv(DST_W, 1'b0);
          4'd4:    op = op_ld(OPD_ZERO, 1'b0);
          4'd5:    op = op_mul(CF_B1, OPD_D0, 1'b0, 1'b0);
          4'd6:    op = op_mul(CF_B2, OPD_D1, 1'b0, 1'b1);
          4'd7:    op = op_mul(CF_B0, OPD_W,  1'b0, 1'b0);
          4'd8:    op = op_sv(DST_Y, 1'b0);
          default: op = op_done();
        endcase
      end
      FORM_DF2T, FORM_SPARE: begin
        unique case (step)
          4'd0:    op = op_ld(OPD_D0, 1'b0);
          4'd1:    op = op_mul(CF_B0, OPD_XQ, 1'b0, 1'b0);
          4'd2:    op = op_sv(DST_Y, 1'b0);
          4'd3:    op = op_ld(OPD_ZERO, 1'b0);
          4'd4:    op = op_ld(OPD_D1, 1'b1);
          4'd5:    op = op_mul(CF_B1, OPD_XQ, 1'b0, 1'b0);
          4'd6:    op = op_mul(CF_A1, OPD_Y,  1'b1, 1'b0);
          4'd7:    op = op_sv(DST_D0, 1'b0);
          4'd8:    op = op_ld(OPD_ZERO, 1'b1);
          4'd9:    op = op_mul(CF_B2, OPD_XQ, 1'b0, 1'b1);
          4'd10:   op = op_mul(CF_A2, OPD_Y,  1'b1, 1'b1);
          4'd11:   op = op_sv(DST_D1, 1'b1);
          default: op = op_done();
        endcase
      end
      default: op = op_done();
    endcase
    return op;
  endfunction

  // Clamp the accumulator to the signed 48-bit range.
  function automatic logic signed [HIST_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (v[ACC_W-1:HIST_W-1] == '0) || (v[ACC_W-1:HIST_W-1] == '1);
    if (fits) begin
      return v[HIST_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      return {1'b0, {(HIST_W-1){1'b1}}};
    end
  endfunction

endpackage

[sv/iir_filter_three_forms_top.sv]
// Top level of the three-form IIR biquad with one shared multiplier and a step sequencer.
//
//  port group      dir  width  contents
//  s_axis_*        in   16     sample_in
//  m_axis_*        out  16+1   sample_out in tdata, clipped in tuser
//  cfg_*           in   3+32   register index, write data
//
// An accepted item runs the form's step program; the next item is taken only after
// its hand-off, once the block is back in idle.
// Each product runs on the single 32x25 multiplier in phases (low half, high half,
// combine, accumulate), and the form's step program sets how many products there are.
// Reset clears configuration to its defaults and all history to zero.
// A result still held at the output stalls the hand-off step of the next item only.
module iir_filter_three_forms_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] sample_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] sample_out
  output logic [0:0]  m_axis_tuser_o,   // [0] clipped
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  iirtf_pkg::state_e state_q, state_d;
  logic [iirtf_pkg::STEP_W-1:0] step_q;
  logic [1:0] phase_q;

  logic [1:0] form_q;
  logic signed [iirtf_pkg::COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;

  logic signed [iirtf_pkg::SAMPLE_W-1:0] x_q, xh1_q, xh2_q;
  logic signed [iirtf_pkg::HIST_W-1:0]   yh1_q, yh2_q, d0_q, d1_q, w_q, y_q;

  logic signed [iirtf_pkg::PROD_W-1:0] prod_q;
  logic signed [iirtf_pkg::LO_W-1:0]   lo_q;
  logic signed [iirtf_pkg::TERM_W-1:0] term_q;
  logic signed [iirtf_pkg::ACC_W-1:0]  acc_q;

  logic        out_valid_q;
  logic [15:0] out_data_q;
  logic        out_clip_q;

  iirtf_pkg::op_t cur_op;
  logic skip, run, out_free, accept;
  logic do_load, do_mul, do_save, do_done;

  logic signed [iirtf_pkg::HIST_W-1:0] opd;
  logic signed [iirtf_pkg::COEF_W-1:0] coef;
  logic signed [24:0]                  mul_b;
  logic signed [iirtf_pkg::PROD_W-1:0] mul_p;
  logic signed [57:0]                  lo_sum, hi_sum;
  logic signed [iirtf_pkg::ACC_W-1:0]  acc_next;
  logic signed [iirtf_pkg::HIST_W-1:0] acc_sat;
  logic signed [48:0]                  rnd;
  logic signed [32:0]                  r_full;
  logic [15:0]                         res_data;
  logic                                res_clip;

  // ---------------- sequencing ----------------
  assign cur_op   = iirtf_pkg::seq_op(form_q, step_q);
  assign skip     = cur_op.two_only && (iirtf_pkg::FILTER_ORDER < 2);
  assign run      = (state_q == iirtf_pkg::ST_RUN) && !skip;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;

  assign do_load = run && (cur_op.kind == iirtf_pkg::OP_LOAD);
  assign do_mul  = run && (cur_op.kind == iirtf_pkg::OP_MUL);
  assign do_save = run && (cur_op.kind == iirtf_pkg::OP_SAVE);
  assign do_done = run && (cur_op.kind == iirtf_pkg::OP_DONE) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iirtf_pkg::ST_IDLE: if (accept) state_d = iirtf_pkg::ST_RUN;
      iirtf_pkg::ST_RUN:  if (do_done) state_d = iirtf_pkg::ST_IDLE;
      default:            state_d = iirtf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      iirtf_pkg::ST_IDLE: s_axis_tready_o = 1'b1;
      iirtf_pkg::ST_RUN:  s_axis_tready_o = 1'b0;
      default:            s_axis_tready_o = 1'b0;
    endcase
  end

  // ---------------- operand and coefficient select ----------------
  always_comb begin
    unique case (cur_op.opd)
      iirtf_pkg::OPD_ZERO: opd = '0;
      iirtf_pkg::OPD_XQ:   opd = {{16{x_q[15]}}, x_q, 16'h0000};
      iirtf_pkg::OPD_X1Q:  opd = {{16{xh1_q[15]}}, xh1_q, 16'h0000};
      iirtf_pkg::OPD_X2Q:  opd = {{16{xh2_q[15]}}, xh2_q, 16'h0000};
      iirtf_pkg::OPD_Y1:   opd = yh1_q;
      iirtf_pkg::OPD_Y2:   opd = yh2_q;
      iirtf_pkg::OPD_D0:   opd = d0_q;
      iirtf_pkg::OPD_D1:   opd = d1_q;
      iirtf_pkg::OPD_W:    opd = w_q;
      iirtf_pkg::OPD_Y:    opd = y_q;
      default:             opd = '0;
    endcase
  end

  always_comb begin
    unique case (cur_op.coef)
      iirtf_pkg::CF_B0: coef = b0_q;
      iirtf_pkg::CF_B1: coef = b1_q;
      iirtf_pkg::CF_B2: coef = b2_q;
      iirtf_pkg::CF_A1: coef = a1_q;
      iirtf_pkg::CF_A2: coef = a2_q;
      default:          coef = b0_q;
    endcase
  end

  // ---------------- shared multiplier and accumulate ----------------
  // Low 24 bits go in unsigned, high 24 bits signed; the halves are recombined with
  // the rounding constant folded into the low product.
  assign mul_b   = (phase_q == iirtf_pkg::PH_LO) ? $signed({1'b0, opd[23:0]})
                                                 : $signed({opd[47], opd[47:24]});
  assign mul_p   = coef * mul_b;
  assign lo_sum  = 58'(prod_q) + 58'sd134217728;
  assign hi_sum  = 58'(prod_q) + 58'(lo_q);
  assign acc_next = cur_op.neg ? (acc_q - 56'(term_q)) : (acc_q + 56'(term_q));
  assign acc_sat  = iirtf_pkg::sat48(acc_q);

  // ---------------- output rounding ----------------
  always_comb begin
    rnd    = 49'(y_q) + 49'sd32768;
    r_full = 33'(rnd >>> 16);
    if ((r_full[32:15] == '0) || (r_full[32:15] == '1)) begin
      res_data = r_full[15:0];
      res_clip = 1'b0;
    end else if (r_full[32]) begin
      res_data = iirtf_pkg::SAMPLE_MIN;
      res_clip = 1'b1;
    end else begin
      res_data = iirtf_pkg::SAMPLE_MAX;
      res_clip = 1'b1;
    end
  end

  // ---------------- control and state registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iirtf_pkg::ST_IDLE;
      step_q      <= '0;
      phase_q     <= iirtf_pkg::PH_LO;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q  <= '0;
        phase_q <= iirtf_pkg::PH_LO;
      end else if (state_q == iirtf_pkg::ST_RUN) begin
        if (skip || do_load || do_save) begin
          step_q <= step_q + 1'b1;
        end else if (do_mul) begin
          phase_q <= phase_q + 1'b1;
          if (phase_q == iirtf_pkg::PH_ACC) step_q <= step_q + 1'b1;
        end else if (do_done) begin
          step_q <= '0;
        end
      end
      if (do_done) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      form_q <= iirtf_pkg::FORM_DF2;
      b0_q   <= 32'sh1000_0000;
      b1_q   <= '0;
      b2_q   <= '0;
      a1_q   <= '0;
      a2_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        iirtf_pkg::REG_FORM: form_q <= cfg_data_i[1:0];
        iirtf_pkg::REG_B0:   b0_q   <= cfg_data_i;
        iirtf_pkg::REG_B1:   b1_q   <= cfg_data_i;
        iirtf_pkg::REG_B2:   b2_q   <= cfg_data_i;
        iirtf_pkg::REG_A1:   a1_q   <= cfg_data_i;
        iirtf_pkg::REG_A2:   a2_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // History: partial sums of the transposed form land mid-program, the rest at hand-off.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xh1_q <= '0;
      xh2_q <= '0;
      yh1_q <= '0;
      yh2_q <= '0;
      d0_q  <= '0;
      d1_q  <= '0;
    end else begin
      if (do_save && (cur_op.dst == iirtf_pkg::DST_D0)) d0_q <= acc_sat;
      if (do_save && (cur_op.dst == iirtf_pkg::DST_D1)) d1_q <= acc_sat;
      if (do_done) begin
        case (form_q) inside
          iirtf_pkg::FORM_DF1: begin
            xh1_q <= x_q;
            xh2_q <= xh1_q;
            yh1_q <= y_q;
            yh2_q <= yh1_q;
          end
          iirtf_pkg::FORM_DF2: begin
            d0_q <= w_q;
            d1_q <= d0_q;
          end
          default: ;
        endcase
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    if (accept) x_q <= s_axis_tdata_i;
    if (do_mul) begin
      unique case (phase_q)
        iirtf_pkg::PH_LO:  prod_q <= mul_p;
        iirtf_pkg::PH_HI: begin
          prod_q <= mul_p;
          lo_q   <= 34'(lo_sum >>> 24);
        end
        iirtf_pkg::PH_SUM: term_q <= 54'(hi_sum >>> 4);
        iirtf_pkg::PH_ACC: acc_q  <= acc_next;
        default: ;
      endcase
    end
    if (do_load) acc_q <= 56'(opd);
    if (do_save && (cur_op.dst == iirtf_pkg::DST_W)) w_q <= acc_sat;
    if (do_save && (cur_op.dst == iirtf_pkg::DST_Y)) y_q <= acc_sat;
    if (do_done) begin
      out_data_q <= res_data;
      out_clip_q <= res_clip;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_clip_q;

  // ---------------- assertions ----------------
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == iirtf_pkg::ST_RUN) && (step_q == '0) && (phase_q == iirtf_pkg::PH_LO))
    else $error("accepted item did not start the step program");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(do_done))
    else $error("result raised outside the hand-off step");

  a_phase_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != iirtf_pkg::PH_LO) |-> ((state_q == iirtf_pkg::ST_RUN) &&
                                       (cur_op.kind == iirtf_pkg::OP_MUL)))
    else $error("multiply phase left mid-product");

  a_clip_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |->
      ((m_axis_tdata_o == 16'h7fff) || (m_axis_tdata_o == 16'h8000)))
    else $error("clipped result not at a limit");

endmodule

[bench/iir_filter_three_forms_top_test.sv]
// Self-checking stream testbench for the three-form IIR biquad section.
`timescale 1ns / 100ps

module iir_filter_three_forms_top_test;

  localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
  localparam int unsigned RANDOM_ITEMS   = 800;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned TAIL_CYCLES    = 40;

  // indexes past the last register; writes there must be dropped
  localparam logic [iirtf_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [iirtf_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [iirtf_pkg::REG_IDX_W-1:0] COEF_REGS [5] = '{
    iirtf_pkg::REG_B0, iirtf_pkg::REG_B1, iirtf_pkg::REG_B2,
    iirtf_pkg::REG_A1, iirtf_pkg::REG_A2
  };

  typedef struct {
    logic signed [iirtf_pkg::SAMPLE_W-1:0] sample_out;
    logic                                  clipped;
  } filtered_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [15:0] in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_data;
  logic [0:0]  out_clip;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  // filter state and registers as the block should hold them
  logic [1:0]                           form_sel = iirtf_pkg::FORM_DF2;
  logic signed [iirtf_pkg::COEF_W-1:0]  k_b0 = 32'sh1000_0000;
  logic signed [iirtf_pkg::COEF_W-1:0]  k_b1 = '0;
  logic signed [iirtf_pkg::COEF_W-1:0]  k_b2 = '0;
  logic signed [iirtf_pkg::COEF_W-1:0]  k_a1 = '0;
  logic signed [iirtf_pkg::COEF_W-1:0]  k_a2 = '0;
  logic signed [iirtf_pkg::SAMPLE_W-1:0] x_past [2] = '{default: '0};
  logic signed [iirtf_pkg::HIST_W-1:0]   y_past [2] = '{default: '0};
  logic signed [iirtf_pkg::HIST_W-1:0]   dly_word [2] = '{default: '0};

  logic [15:0] pending_samples [$];
  filtered_t   expected_out [$];
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  bit          steady_flow   = 1'b0;
  int unsigned send_hold     = 0;
  int unsigned recv_hold     = 0;

  iir_filter_three_forms_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),    // [15:0] sample_in
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),   // [15:0] sample_out
    .m_axis_tuser_o  (out_clip),   // [0] clipped
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Q4.28 coefficient times Q32.16 word, rounded half up back to Q32.16
  function automatic logic signed [63:0] coef_mul(
      input logic signed [iirtf_pkg::COEF_W-1:0] c, input logic signed [63:0] h);
    logic signed [95:0] p;
    p = c * h;
    p = p + (96'sd1 <<< 27);
    return p >>> 28;
  endfunction

  function automatic logic signed [iirtf_pkg::HIST_W-1:0] clamp48(
      input logic signed [63:0] v);
    if (v > 64'sh0000_7FFF_FFFF_FFFF) return {1'b0, {(iirtf_pkg::HIST_W-1){1'b1}}};
    if (v < -64'sh0000_8000_0000_0000) return {1'b1, {(iirtf_pkg::HIST_W-1){1'b0}}};
    return v[iirtf_pkg::HIST_W-1:0];
  endfunction

  // Advance the filter by one sample and return the rounded, saturated output.
  function automatic filtered_t filter_step(input logic signed [iirtf_pkg::SAMPLE_W-1:0] x);
    logic signed [63:0] xq, acc, w, h1, h2, r;
    filtered_t res;
    bit two;
    two = iirtf_pkg::FILTER_ORDER >= 2;
    xq = x;
    xq = xq <<< 16;
    if (form_sel == iirtf_pkg::FORM_DF1) begin
      h1 = x_past[0];
      h2 = x_past[1];
      acc = coef_mul(k_b0, xq) + coef_mul(k_b1, h1 <<< 16) - coef_mul(k_a1, y_past[0]);
      if (two) acc = acc + coef_mul(k_b2, h2 <<< 16) - coef_mul(k_a2, y_past[1]);
      acc = clamp48(acc);
      x_past[1] = x_past[0];
      x_past[0] = x;
      y_past[1] = y_past[0];
      y_past[0] = acc[iirtf_pkg::HIST_W-1:0];
    end else if (form_sel == iirtf_pkg::FORM_DF2) begin
      w = xq - coef_mul(k_a1, dly_word[0]);
      acc = coef_mul(k_b1, dly_word[0]);
      if (two) begin
        w = w - coef_mul(k_a2, dly_word[1]);
        acc = acc + coef_mul(k_b2, dly_word[1]);
      end
      w = clamp48(w);
      acc = clamp48(acc + coef_mul(k_b0, w));
      dly_word[1] = dly_word[0];
      dly_word[0] = w[iirtf_pkg::HIST_W-1:0];
    end else begin
      // transposed form; the spare code behaves the same
      acc = clamp48(dly_word[0] + coef_mul(k_b0, xq));
      if (two) begin
        dly_word[0] = clamp48(dly_word[1] + coef_mul(k_b1, xq) - coef_mul(k_a1, acc));
        dly_word[1] = clamp48(coef_mul(k_b2, xq) - coef_mul(k_a2, acc));
      end else begin
        dly_word[0] = clamp48(coef_mul(k_b1, xq) - coef_mul(k_a1, acc));
      end
    end
    r = (acc + 64'sd32768) >>> 16;
    res.clipped = 1'b0;
    if (r > iirtf_pkg::SAMPLE_MAX) begin
      r = iirtf_pkg::SAMPLE_MAX;
      res.clipped = 1'b1;
    end else if (r < iirtf_pkg::SAMPLE_MIN) begin
      r = iirtf_pkg::SAMPLE_MIN;
      res.clipped = 1'b1;
    end
    res.sample_out = r[iirtf_pkg::SAMPLE_W-1:0];
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(31, 120);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4, 5:    return 16'($urandom_range(0, 511) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3, 4:    return $urandom;
      // mostly within +/-1.0 so that the section stays near stable
      default: return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
    endcase
  endfunction

  task automatic write_reg(input logic [iirtf_pkg::REG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      iirtf_pkg::REG_FORM: form_sel = val[1:0];
      iirtf_pkg::REG_B0:   k_b0 = val;
      iirtf_pkg::REG_B1:   k_b1 = val;
      iirtf_pkg::REG_B2:   k_b2 = val;
      iirtf_pkg::REG_A1:   k_a1 = val;
      iirtf_pkg::REG_A2:   k_a2 = val;
      default:  ;
    endcase
  endtask

  task automatic queue_sample(input logic [15:0] s);
    pending_samples.push_back(s);
    items_sent++;
  endtask

  // wait for every queued item to come back, then let the block go quiet
  task automatic settle();
    while (results_seen < items_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: take the next item from the queue, with random gaps between items
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) expected_out.push_back(filter_step(in_data));
      if (!in_valid || in_ready) begin
        if (send_hold > 0) begin
          send_hold--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_data   <= pending_samples.pop_front();
          in_valid  <= 1'b1;
          send_hold = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result against the oldest expectation, stall at random
  always @(posedge clk) begin
    filtered_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_out.size() == 0) begin
          $error("result with no item pending: sample_out %0d clipped %0d",
                 $signed(out_data), out_clip);
          mismatches++;
        end else begin
          want = expected_out.pop_front();
          if (out_data !== want.sample_out) begin
            $error("sample_out: expected %0d, got %0d", want.sample_out, $signed(out_data));
            mismatches++;
          end
          if (out_clip[0] !== want.clipped) begin
            $error("clipped: expected %0d, got %0d", want.clipped, out_clip);
            mismatches++;
          end
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 4) == 0) begin
        recv_hold = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned random_sent;
    int unsigned len;
    logic [31:0] form_word;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset settings pass the input straight through
    queue_sample(16'h0000);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    queue_sample(16'hFFFF);
    queue_sample(16'h0001);
    settle();

    // writes past the last register change nothing
    write_reg(REG_SPARE_LO, 32'h0000_0000);
    write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
    queue_sample(16'h04D2);
    settle();

    // extreme coefficients: output clips, stored sums saturate
    write_reg(iirtf_pkg::REG_FORM, 32'(iirtf_pkg::FORM_DF1));
    write_reg(iirtf_pkg::REG_B0, 32'h7FFF_FFFF);
    write_reg(iirtf_pkg::REG_B1, 32'h8000_0000);
    write_reg(iirtf_pkg::REG_B2, 32'h7FFF_FFFF);
    write_reg(iirtf_pkg::REG_A1, 32'h8000_0000);
    write_reg(iirtf_pkg::REG_A2, 32'h7FFF_FFFF);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    settle();

    // spare form code, set through the upper data bits too
    write_reg(iirtf_pkg::REG_FORM, 32'hFFFF_FFFF);
    queue_sample(16'd100);
    queue_sample(-16'sd100);
    queue_sample(16'h7FFF);
    settle();

    // switch to direct form II with the saturated history left in place
    write_reg(iirtf_pkg::REG_FORM, 32'(iirtf_pkg::FORM_DF2));
    queue_sample(16'h0001);
    queue_sample(16'hFFFF);
    queue_sample(16'h0000);
    settle();

    // ordinary low-pass in the transposed form
    write_reg(iirtf_pkg::REG_FORM, 32'(iirtf_pkg::FORM_DF2T));
    write_reg(iirtf_pkg::REG_B0, 32'h0040_0000);
    write_reg(iirtf_pkg::REG_B1, 32'h0080_0000);
    write_reg(iirtf_pkg::REG_B2, 32'h0040_0000);
    write_reg(iirtf_pkg::REG_A1, 32'hE400_0000);
    write_reg(iirtf_pkg::REG_A2, 32'h0C00_0000);
    queue_sample(16'h7FFF);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    queue_sample(16'h1234);
    settle();

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      steady_flow = ($urandom_range(0, 4) == 0);
      form_word = $urandom;
      form_word[1:0] = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
        0: write_reg(iirtf_pkg::REG_FORM, form_word);  // form change only, history kept
        1: begin
          write_reg(iirtf_pkg::REG_FORM, form_word);
          foreach (COEF_REGS[i]) write_reg(COEF_REGS[i], pick_coef());
        end
        default: begin
          write_reg(iirtf_pkg::REG_FORM, form_word);
          foreach (COEF_REGS[i]) if ($urandom_range(0, 1) == 0) write_reg(COEF_REGS[i], pick_coef());
        end
      endcase
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
      len = $urandom_range(10, 90);
      repeat (len) queue_sample(pick_sample());
      random_sent += len;
      settle();
    end

    steady_flow = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_out.size() != 0) begin
      $error("%0d expected results never arrived", expected_out.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[iir_filter_three_forms_top] OK");
    end else begin
      $display("[iir_filter_three_forms_top] ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("[iir_filter_three_forms_top] ERROR");
    $finish;
  end

endmodule

[iir_filter_three_forms_top.f]
sv/iirtf_pkg.sv
sv/iir_filter_three_forms_top.sv
bench/iir_filter_three_forms_top_test.sv
